### rtl/core/ptac_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and colour arithmetic for the palette texel converter
package ptac_pkg;

    localparam int PALETTE_ENTRIES = 256;
    localparam int PALETTE_BANKS   = 5;

    // operation codes on the input channel
    localparam logic [1:0] OP_PAL_WRITE = 2'd0;
    localparam logic [1:0] OP_INDEXED   = 2'd1;
    localparam logic [1:0] OP_TRUECOLOR = 2'd2;

    // configuration register indexes
    localparam logic [1:0] CFG_BRIGHTNESS = 2'd0;
    localparam logic [1:0] CFG_ALPHA_MAP  = 2'd1;
    localparam logic [1:0] CFG_ILLUM_MAP  = 2'd2;

    localparam logic [2:0]  LEVEL_MAX    = 3'd4;
    localparam logic [4:0]  SCALE_BASE   = 5'd12;
    localparam logic [7:0]  ILLUM_ON     = 8'h7f;
    localparam logic [7:0]  ALPHA_OPAQUE = 8'hff;
    localparam logic [24:0] R5_GAIN      = 25'd539086;
    localparam logic [24:0] G6_GAIN      = 25'd265264;
    localparam logic [24:0] ROUND_HALF   = 25'd32768;

    typedef logic [15:0] rgb565_t;

    // pixel word held between the palette read and the colour stage
    typedef struct packed {
        logic        indexed;
        logic [7:0]  alpha_value;
        logic [7:0]  illum_value;
        logic [31:0] true_color;
        logic        last_pixel;
    } item_t;

    // configuration as the colour stage sees it, level already saturated
    typedef struct packed {
        logic       alpha_map;
        logic       illum_map;
        logic [2:0] level;
    } mode_t;

    typedef struct packed {
        logic [31:0] pixel_argb;
        logic [7:0]  illum_level;
        logic        illum_hit;
    } calc_t;

    // 5-bit channel to 8 bits with rounding
    function automatic logic [7:0] expand5(input logic [4:0] c);
        logic [24:0] prod;
        prod = 25'(c) * R5_GAIN + ROUND_HALF;
        return prod[23:16];
    endfunction

    // 6-bit channel to 8 bits with rounding
    function automatic logic [7:0] expand6(input logic [5:0] c);
        logic [24:0] prod;
        prod = 25'(c) * G6_GAIN + ROUND_HALF;
        return prod[23:16];
    endfunction

    // channel times mult / 16, truncated to 8 bits
    function automatic logic [7:0] scale_ch(input logic [7:0] v, input logic [4:0] mult);
        logic [12:0] prod;
        prod = 13'(v) * 13'(mult);
        return prod[11:4];
    endfunction

endpackage

### rtl/core/ptac_pixel_calc.sv
`timescale 1ns / 1ps
// colour stage: classification, rgb565 expansion and channel scaling
module ptac_pixel_calc (
    input  ptac_pkg::item_t                                    item,
    input  ptac_pkg::mode_t                                    mode,
    input  logic [ptac_pkg::PALETTE_BANKS-1:0][15:0]           bank_data,
    output ptac_pkg::calc_t                                    res
);

    ptac_pkg::rgb565_t c4;
    ptac_pkg::rgb565_t c8;
    ptac_pkg::rgb565_t disp;
    logic              dark;
    logic              alpha_ok;
    logic              hit;
    logic [4:0]        mult;
    logic [7:0]        tc_a;
    logic [7:0]        tc_illum;
    logic [7:0]        idx_a;

    always_comb
    begin
        c4   = bank_data[0];
        c8   = bank_data[ptac_pkg::PALETTE_BANKS-1];
        disp = bank_data[mode.level];

        dark     = (c4[15:11] <= 5'd8) && (c4[10:5] <= 6'd16) && (c4[4:0] <= 5'd8);
        alpha_ok = !mode.alpha_map || (item.alpha_value == ptac_pkg::ALPHA_OPAQUE);
        hit      = !dark && alpha_ok && (c4 == c8);
        idx_a    = (!mode.alpha_map || hit) ? ptac_pkg::ALPHA_OPAQUE : item.alpha_value;

        mult     = ptac_pkg::SCALE_BASE + 5'(mode.level);
        tc_a     = item.true_color[31:24];
        tc_illum = (mode.illum_map && (tc_a == ptac_pkg::ALPHA_OPAQUE)) ?
                   item.illum_value : 8'd0;

        if (item.indexed)
        begin
            res.pixel_argb  = {idx_a, ptac_pkg::expand5(disp[15:11]),
                               ptac_pkg::expand6(disp[10:5]), ptac_pkg::expand5(disp[4:0])};
            res.illum_level = hit ? ptac_pkg::ILLUM_ON : 8'd0;
            res.illum_hit   = hit;
        end
        else
        begin
            // lit texels keep their colour, the rest are scaled by the brightness level
            if (tc_illum != 8'd0)
            begin
                res.pixel_argb = item.true_color;
            end
            else
            begin
                res.pixel_argb = {tc_a,
                                  ptac_pkg::scale_ch(item.true_color[23:16], mult),
                                  ptac_pkg::scale_ch(item.true_color[15:8], mult),
                                  ptac_pkg::scale_ch(item.true_color[7:0], mult)};
            end
            res.illum_level = tc_illum;
            res.illum_hit   = 1'b0;
        end
    end

endmodule

### rtl/core/palette_texel_to_argb_converter_top.sv
`timescale 1ns / 1ps
// top level of the palette texel to argb8888 converter
//
// usage
//  - input channel (in_valid/in_ready) carries one word per op: palette write,
//    indexed pixel or truecolor argb pixel; op code three is dropped
//  - palette writes and dropped ops give no output word; each pixel op gives
//    exactly one output word (out_valid/out_ready), in input order
//  - configuration (brightness, alpha map, illum map) is written through
//    cfg_wr_en/cfg_addr/cfg_wdata while no pixel is in flight
//  - throughput one word per cycle while the receiver keeps out_ready high; an
//    accepted word passes the palette read at the accept edge, then the colour
//    stage into the output register, which raises out_valid
//  - the five palette banks are separate 256 x 16 synchronous memories all
//    read at the pixel index, so one read port each covers the row-4, row-8
//    and display colour lookups in the same cycle
//  - reset clears the pipeline, the configuration and the illum-seen flag;
//    palette contents are not cleared and must be loaded before use
//  - a stalled receiver holds the output register; one more pixel waits in
//    the colour stage and then in_ready drops
module palette_texel_to_argb_converter_top (
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  op,
    input  logic [2:0]  palette_bank,
    input  logic [7:0]  color_index,
    input  logic [15:0] palette_color,
    input  logic [7:0]  alpha_value,
    input  logic [7:0]  illum_value,
    input  logic [31:0] true_color,
    input  logic        last_pixel,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] pixel_argb,
    output logic [7:0]  illum_level,
    output logic        illum_seen,
    output logic        last_out,

    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [2:0]  cfg_wdata
);

    // configuration registers
    logic [2:0] brightness_level_reg;
    logic       alpha_map_present_reg;
    logic       illum_map_present_reg;

    // colour stage
    logic            s1_valid_reg;
    ptac_pkg::item_t s1_item_reg;
    ptac_pkg::item_t s1_item_next;
    logic            s1_go;

    // output register
    logic        out_valid_reg;
    logic [31:0] pixel_argb_reg;
    logic [7:0]  illum_level_reg;
    logic        illum_seen_reg;
    logic        last_out_reg;

    // sticky illumination flag
    logic illum_flag_reg;
    logic illum_flag_next;
    logic seen_now;

    logic                                        in_fire;
    logic                                        is_pixel;
    logic                                        pal_wr;
    logic [ptac_pkg::PALETTE_BANKS-1:0][15:0]    rd_data;
    ptac_pkg::mode_t                             mode;
    ptac_pkg::calc_t                             calc;

    assign in_fire  = in_valid && in_ready;
    assign is_pixel = (op == ptac_pkg::OP_INDEXED) || (op == ptac_pkg::OP_TRUECOLOR);
    assign pal_wr   = in_fire && (op == ptac_pkg::OP_PAL_WRITE);

    // colour stage moves when the output register is free or being emptied
    assign s1_go    = !out_valid_reg || out_ready;
    assign in_ready = s1_go || !s1_valid_reg;

    // configuration port, index three is not a register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_level_reg  <= 3'd0;
            alpha_map_present_reg <= 1'b0;
            illum_map_present_reg <= 1'b0;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                ptac_pkg::CFG_BRIGHTNESS: brightness_level_reg  <= cfg_wdata;
                ptac_pkg::CFG_ALPHA_MAP:  alpha_map_present_reg <= cfg_wdata[0];
                ptac_pkg::CFG_ILLUM_MAP:  illum_map_present_reg <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    assign mode.alpha_map = alpha_map_present_reg;
    assign mode.illum_map = illum_map_present_reg;
    assign mode.level     = (brightness_level_reg > ptac_pkg::LEVEL_MAX) ?
                            ptac_pkg::LEVEL_MAX : brightness_level_reg;

    // palette banks: write on a palette op, read all banks at the pixel index
    for (genvar k = 0; k < ptac_pkg::PALETTE_BANKS; k++)
    begin : g_bank
        logic [15:0] mem [ptac_pkg::PALETTE_ENTRIES];
        logic [15:0] rd_reg;

        always_ff @(posedge clk)
        begin
            if (pal_wr && (palette_bank == 3'(k)))
            begin
                mem[color_index] <= palette_color;
            end
            if (in_fire && (op == ptac_pkg::OP_INDEXED))
            begin
                rd_reg <= mem[color_index];
            end
        end

        assign rd_data[k] = rd_reg;
    end

    // pixel word travelling beside the memory read
    always_comb
    begin
        s1_item_next.indexed     = (op == ptac_pkg::OP_INDEXED);
        s1_item_next.alpha_value = alpha_value;
        s1_item_next.illum_value = illum_value;
        s1_item_next.true_color  = true_color;
        s1_item_next.last_pixel  = last_pixel;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_fire && is_pixel;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && is_pixel)
        begin
            s1_item_reg <= s1_item_next;
        end
    end

    ptac_pixel_calc u_calc (
        .item      (s1_item_reg),
        .mode      (mode),
        .bank_data (rd_data),
        .res       (calc)
    );

    // flag shown includes this pixel, then clears after the last one
    assign seen_now        = illum_flag_reg || calc.illum_hit;
    assign illum_flag_next = s1_item_reg.last_pixel ? 1'b0 : seen_now;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            illum_flag_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else if (s1_go)
        begin
            out_valid_reg <= s1_valid_reg;
            if (s1_valid_reg)
            begin
                illum_flag_reg <= illum_flag_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_go && s1_valid_reg)
        begin
            pixel_argb_reg  <= calc.pixel_argb;
            illum_level_reg <= calc.illum_level;
            illum_seen_reg  <= seen_now;
            last_out_reg    <= s1_item_reg.last_pixel;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pixel_argb  = pixel_argb_reg;
    assign illum_level = illum_level_reg;
    assign illum_seen  = illum_seen_reg;
    assign last_out    = last_out_reg;

endmodule

### rtl/core/ptac_port_checker.sv
`timescale 1ns / 1ps
// port-level checker for the palette texel converter, bound to the top level
module ptac_port_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] pixel_argb,
    input logic [7:0]  illum_level,
    input logic        illum_seen,
    input logic        last_out
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pixel_argb)
            && $stable(illum_level) && $stable(illum_seen) && $stable(last_out))
        else $error("output word changed while stalled");

    // any lit pixel is opaque
    a_lit_opaque: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (illum_level != 8'd0) |-> pixel_argb[31:24] == 8'hff)
        else $error("lit pixel without full alpha");

    // pipeline is empty on the first edge after reset
    a_reset_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !$past(rst_n) |-> !out_valid)
        else $error("output word after reset");

    // a fresh output word comes from an input word accepted earlier
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("output word without matching input");

endmodule

bind palette_texel_to_argb_converter_top ptac_port_checker u_ptac_port_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .pixel_argb  (pixel_argb),
    .illum_level (illum_level),
    .illum_seen  (illum_seen),
    .last_out    (last_out)
);
